// ===== design/lgf_pkg.sv =====
// Shared types, constants and elaboration-time kernel math for the LoG filter.
`default_nettype none
package lgf_pkg;

  localparam int PIX_W  = 8;
  localparam int COEF_W = 24;
  localparam int RES_W  = 32;
  localparam int POS_W  = 10;
  localparam int ACC_W  = 42;
  localparam int CFG_W  = 11;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [63:0] Q60_ONE = 64'h1000_0000_0000_0000;
  localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // one window tap issued to the MAC, aligned with the line store read
  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic signed [COEF_W-1:0] coef;
  } tap_t;

  // restoring divide, used only when building constants
  function automatic logic [63:0] lgf_udiv(logic [63:0] a, logic [63:0] b);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      q = {q[62:0], 1'b0};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] lgf_mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // floor(num * 2^60 / den) of the fractional part
  function automatic logic [63:0] lgf_frac(logic [63:0] num, logic [63:0] den);
    logic [63:0] r;
    logic [63:0] q;
    q = '0;
    r = num - lgf_udiv(num, den) * den;
    for (int i = 0; i < 60; i++) begin
      r = {r[62:0], 1'b0};
      q = {q[62:0], 1'b0};
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-num/den) in Q60: series on x/32, then five squarings
  function automatic logic [63:0] lgf_exp_neg(logic [63:0] num, logic [63:0] den);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] term;
    x    = lgf_frac(num, {den[58:0], 5'd0});
    y    = Q60_ONE;
    term = Q60_ONE;
    for (int n = 1; n < 48; n++) begin
      term = lgf_udiv(lgf_mul_q60(term, x), 64'(n));
      if (term == '0) break;
      if (n % 2 == 1) y = y - term;
      else y = y + term;
    end
    for (int k = 0; k < 5; k++) y = lgf_mul_q60(y, y);
    return y;
  endfunction

  // Q4.20 coefficient for squared radius r2
  function automatic logic signed [COEF_W-1:0] lgf_coef(int sigma_tenths, int r2);
    logic [63:0]  s2;
    logic [63:0]  s6;
    logic [63:0]  a;
    logic [63:0]  e;
    logic         neg;
    logic [63:0]  n;
    logic [127:0] p;
    logic [64:0]  rem;
    logic [63:0]  q;
    logic [63:0]  mag;
    s2  = 64'(sigma_tenths) * 64'(sigma_tenths);
    s6  = s2 * s2 * s2;
    a   = 64'd50 * 64'(r2);
    e   = lgf_exp_neg(a, s2);
    neg = a < s2;
    n   = (neg ? s2 - a : a - s2) * 64'd10000;
    p   = {64'd0, n} * {64'd0, e};
    p   = p << 21;
    rem = '0;
    q   = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[63:0], p[i]};
      q   = {q[62:0], 1'b0};
      if (rem >= {1'b0, PI_Q60}) begin
        rem  = rem - {1'b0, PI_Q60};
        q[0] = 1'b1;
      end
    end
    mag = lgf_udiv(q + s6, {s6[62:0], 1'b0});
    if (neg) begin
      if (mag > 64'h80_0000) mag = 64'h80_0000;
      return -(COEF_W'(mag));
    end
    if (mag > 64'h7F_FFFF) mag = 64'h7F_FFFF;
    return COEF_W'(mag);
  endfunction

endpackage
`default_nettype wire

// ===== design/lgf_line_mem.sv =====
// Line store: ring of source rows, one write and one registered read port.
`default_nettype none
module lgf_line_mem #(
  parameter int DEPTH = 18432,
  parameter int AW    = 15
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic [lgf_pkg::PIX_W-1:0] wdata,
  input  wire logic [AW-1:0]           raddr,
  output logic      [lgf_pkg::PIX_W-1:0] rdata
);
  import lgf_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/lgf_mac.sv =====
// Window multiply-accumulate with Q16.16 rounding and saturation.
`default_nettype none
module lgf_mac (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             clear,
  input  wire lgf_pkg::tap_t                    tap,
  input  wire logic [lgf_pkg::PIX_W-1:0]        pixel,
  output logic signed [lgf_pkg::RES_W-1:0]      res,
  output logic                                  res_valid
);
  import lgf_pkg::*;

  localparam int PROD_W = PIX_W + 1 + COEF_W;
  localparam int RND_W  = ACC_W - 3;

  tap_t                     tap_d;
  logic signed [PROD_W-1:0] prod;
  logic                     p_valid;
  logic                     p_last;
  logic signed [ACC_W-1:0]  acc;
  logic                     a_last;
  logic signed [ACC_W:0]    biased;
  logic signed [RND_W-1:0]  rounded;
  logic signed [RES_W-1:0]  sat;

  // tap is registered once so that it lines up with the line store read data
  always_ff @(posedge clk) begin
    tap_d.coef <= tap.coef;
    tap_d.last <= tap.last;
    prod       <= $signed({1'b0, pixel}) * tap_d.coef;
    p_last     <= tap_d.last;
    if (rst) begin
      tap_d.valid <= 1'b0;
      p_valid     <= 1'b0;
      a_last      <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      tap_d.valid <= tap.valid;
      p_valid     <= tap_d.valid;
      a_last      <= p_valid && p_last;
      res_valid   <= a_last;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (p_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // floor((acc + 8) / 16), clipped to 32 bits
  always_comb begin
    biased  = (ACC_W + 1)'(acc) + (ACC_W + 1)'(8);
    rounded = biased[ACC_W:4];
    if (rounded > RND_W'(signed'(32'sh7FFF_FFFF))) begin
      sat = 32'sh7FFF_FFFF;
    end else if (rounded < RND_W'(signed'(32'sh8000_0000))) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = RES_W'(rounded);
    end
  end

  always_ff @(posedge clk) begin
    if (a_last) begin
      res <= sat;
    end
  end

endmodule
`default_nettype wire

// ===== design/laplacian_of_gaussian_filter.sv =====
// Top level: raster Laplacian-of-Gaussian filter over a line store ring.
// Flow: an accepted word goes to ST_CHECK; if it completes a window, ST_RUN issues
//   every tap of the TAPS x TAPS window (9 x 9 at the default sigma of 1.0), ST_DRAIN
//   waits for the MAC result and ST_DONE loads the output word once it is free.
// One word at a time, taken only in ST_IDLE; set by the single MAC and line store read port.
// Reset: counters, sizes (1024 x 1024) and handshakes clear at once; the line
//   store is not cleared, every entry read is written earlier in the frame.
`default_nettype none
module laplacian_of_gaussian_filter #(
  parameter int SIGMA_TENTHS = 10,
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_HEIGHT   = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave word
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] pixel
  input  wire logic        s_tuser,   // [0] op: pixel or drain
  // master word
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [31:0] filtered, [41:32] column, [51:42] row
  output logic             m_tlast,   // frame_last
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index, // 0 frame_width, 1 frame_height
  input  wire logic [10:0] cfg_data
);
  import lgf_pkg::*;

  localparam int HALF  = (42 * SIGMA_TENTHS) / 100;
  localparam int TAPS  = 2 * HALF + 1;
  localparam int RING  = 2 * HALF + 2;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int SW    = $clog2(RING);
  localparam int TW    = $clog2(TAPS);
  localparam int AW    = SW + CW;
  localparam int DEPTH = RING * (2 ** CW);
  localparam int R2_N  = 2 * HALF * HALF + 1;
  localparam int R2W   = $clog2(R2_N);
  localparam int XW    = CW + 2;   // signed column arithmetic
  localparam int YW    = RW + 2;   // signed row arithmetic
  localparam int LW    = SW + 2;   // signed slot arithmetic

  // kernel by squared radius, built at elaboration
  logic signed [COEF_W-1:0] kern_tab [R2_N];
  for (genvar g = 0; g < R2_N; g++) begin : g_kern
    localparam logic signed [COEF_W-1:0] C = lgf_coef(SIGMA_TENTHS, g);
    assign kern_tab[g] = C;
  end

  state_t state, state_next;

  logic [CFG_W-1:0] frame_width, frame_height;
  logic [CW:0]      w_eff;
  logic [RW:0]      h_eff;

  logic [CW-1:0] in_column, out_column;
  logic [RW-1:0] in_row, out_row;
  logic [SW-1:0] in_slot, out_slot;
  logic          frame_complete;
  logic          skip;
  logic [TW-1:0] ty, tx;

  logic          s_accept, pix_write, emit_ok, out_free, tap_last;
  logic [RW:0]   ry;
  logic [CW:0]   rx;
  logic [CW:0]   col_inc, ocol_inc;
  logic [RW:0]   row_inc, orow_inc;

  logic signed [YW-1:0] yy, yoff;
  logic signed [XW-1:0] xx;
  logic signed [LW-1:0] sl;
  logic [TW-1:0]        adx, ady;
  logic [R2W-1:0]       r2;

  logic [AW-1:0]       waddr, raddr;
  logic [PIX_W-1:0]    rdata;
  tap_t                tap;
  logic                mac_clear, res_valid;
  logic signed [RES_W-1:0] res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(1024);
      frame_height <= CFG_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (frame_width == '0) w_eff = (CW + 1)'(1);
    else if (32'(frame_width) > MAX_WIDTH) w_eff = (CW + 1)'(MAX_WIDTH);
    else w_eff = (CW + 1)'(frame_width);
    if (frame_height == '0) h_eff = (RW + 1)'(1);
    else if (32'(frame_height) > MAX_HEIGHT) h_eff = (RW + 1)'(MAX_HEIGHT);
    else h_eff = (RW + 1)'(frame_height);
  end

  assign s_accept  = s_tvalid && s_tready;
  assign pix_write = s_accept && (s_tuser == OP_PIXEL) && !frame_complete;
  assign out_free  = !m_tvalid || m_tready;
  assign col_inc   = {1'b0, in_column} + 1'b1;
  assign row_inc   = {1'b0, in_row} + 1'b1;
  assign ocol_inc  = {1'b0, out_column} + 1'b1;
  assign orow_inc  = {1'b0, out_row} + 1'b1;
  assign tap_last  = (ty == TW'(TAPS - 1)) && (tx == TW'(TAPS - 1));

  // a pixel that arrives while the backlog is owed is dropped with no result
  always_ff @(posedge clk) begin
    if (rst) begin
      skip <= 1'b0;
    end else if (s_accept) begin
      skip <= (s_tuser == OP_PIXEL) && frame_complete;
    end
  end

  // is the window of the next output fully received
  always_comb begin
    ry = (RW + 1)'(out_row) + (RW + 1)'(HALF);
    if (ry > h_eff - 1'b1) ry = h_eff - 1'b1;
    rx = (CW + 1)'(out_column) + (CW + 1)'(HALF);
    if (rx > w_eff - 1'b1) rx = w_eff - 1'b1;
    emit_ok = frame_complete || ((RW + 1)'(in_row) > ry) ||
              (((RW + 1)'(in_row) == ry) && ((CW + 1)'(in_column) > rx));
  end

  // tap address: clamp to the frame edge, slot found relative to out_slot
  always_comb begin
    yy = YW'(out_row) + YW'(ty) - YW'(HALF);
    if (yy < 0) yy = '0;
    else if (yy > YW'(h_eff) - YW'(1)) yy = YW'(h_eff) - YW'(1);
    yoff = yy - YW'(out_row);
    sl   = LW'(out_slot) + LW'(yoff);
    if (sl < 0) sl = sl + LW'(RING);
    else if (sl >= LW'(RING)) sl = sl - LW'(RING);
    xx = XW'(out_column) + XW'(tx) - XW'(HALF);
    if (xx < 0) xx = '0;
    else if (xx > XW'(w_eff) - XW'(1)) xx = XW'(w_eff) - XW'(1);
    raddr = {SW'(sl), CW'(xx)};
    adx = (tx >= TW'(HALF)) ? tx - TW'(HALF) : TW'(HALF) - tx;
    ady = (ty >= TW'(HALF)) ? ty - TW'(HALF) : TW'(HALF) - ty;
    r2  = R2W'(adx) * R2W'(adx) + R2W'(ady) * R2W'(ady);
  end

  assign waddr = {in_slot, in_column};

  always_comb begin
    tap.valid = (state == ST_RUN);
    tap.last  = tap_last;
    tap.coef  = kern_tab[r2];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mac_clear  = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (emit_ok && !skip) begin
          mac_clear  = 1'b1;
          state_next = ST_RUN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (tap_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (res_valid) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // tap counters
  always_ff @(posedge clk) begin
    if (rst || state == ST_CHECK) begin
      ty <= '0;
      tx <= '0;
    end else if (state == ST_RUN) begin
      if (tx == TW'(TAPS - 1)) begin
        tx <= '0;
        ty <= ty + 1'b1;
      end else begin
        tx <= tx + 1'b1;
      end
    end
  end

  // input and output raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      in_column      <= '0;
      in_row         <= '0;
      in_slot        <= '0;
      out_column     <= '0;
      out_row        <= '0;
      out_slot       <= '0;
      frame_complete <= 1'b0;
    end else if (pix_write) begin
      if (col_inc >= w_eff) begin
        in_column <= '0;
        if (row_inc >= h_eff) begin
          in_row         <= '0;
          in_slot        <= '0;
          frame_complete <= 1'b1;
        end else begin
          in_row  <= RW'(row_inc);
          in_slot <= (in_slot == SW'(RING - 1)) ? '0 : in_slot + 1'b1;
        end
      end else begin
        in_column <= CW'(col_inc);
      end
    end else if (state == ST_DONE && out_free) begin
      if (ocol_inc >= w_eff) begin
        out_column <= '0;
        if (orow_inc >= h_eff) begin
          out_row        <= '0;
          out_slot       <= '0;
          frame_complete <= 1'b0;
        end else begin
          out_row  <= RW'(orow_inc);
          out_slot <= (out_slot == SW'(RING - 1)) ? '0 : out_slot + 1'b1;
        end
      end else begin
        out_column <= CW'(ocol_inc);
      end
    end
  end

  // output register; frees the core while the word waits
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {4'd0, POS_W'(out_row), POS_W'(out_column), res};
      m_tlast <= (ocol_inc >= w_eff) && (orow_inc >= h_eff);
    end
  end

  lgf_line_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (pix_write),
    .waddr(waddr),
    .wdata(s_tdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  lgf_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .clear    (mac_clear),
    .tap      (tap),
    .pixel    (rdata),
    .res      (res),
    .res_valid(res_valid)
  );

endmodule
`default_nettype wire

// ===== design/lgf_checker.sv =====
// Port-level checks for the LoG filter, bound to the top level.
`default_nettype none
module lgf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic        m_tlast
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // one word in flight: an accepted word is always followed by a busy cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted back to back");

  // a new result is loaded only while the core is busy
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while idle");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind laplacian_of_gaussian_filter lgf_checker u_lgf_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);
`default_nettype wire
